### sv/aos_pkg.sv
// ----------------------------------------------------------------------------
// aos_pkg
// Shared types and constants for the ADC averaging, offset and scaling block.
// ----------------------------------------------------------------------------
package aos_pkg;

  // Configuration register indexes (byte address is four times the index).
  localparam int unsigned CFG_ADDR_W   = 5;
  localparam logic [2:0]  REG_VREF     = 3'd0;
  localparam logic [2:0]  REG_GAIN     = 3'd1;
  localparam logic [2:0]  REG_TRIM     = 3'd2;
  localparam logic [2:0]  REG_DIG_UV   = 3'd3;
  localparam logic [2:0]  REG_DIG_MV   = 3'd4;
  localparam logic [2:0]  REG_DIG_V    = 3'd5;

  localparam logic [22:0] VREF_RESET   = 23'd4096000;
  localparam logic [3:0]  GAIN_RESET   = 4'd10;
  localparam logic [20:0] TRIM_RESET   = 21'd0;
  localparam logic [2:0]  DIG_UV_RESET = 3'd0;
  localparam logic [2:0]  DIG_MV_RESET = 3'd2;
  localparam logic [2:0]  DIG_V_RESET  = 3'd6;

  // Datapath widths. The difference covers a 24-bit code, a 24-bit offset
  // and the 21-bit trim; the multiplier takes diff*gain and then that
  // product times the reference.
  localparam int unsigned DIFF_W  = 26;
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 25;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned UV_W    = 28;
  localparam int unsigned OFFS_W  = 24;

  localparam int MILLI_LIMIT = 1000;
  localparam int VOLT_LIMIT  = 1000000;

  localparam logic [1:0] UNIT_UV = 2'd0;
  localparam logic [1:0] UNIT_MV = 2'd1;
  localparam logic [1:0] UNIT_V  = 2'd2;

  localparam logic KIND_MEASURE = 1'b0;
  localparam logic KIND_CAL     = 1'b1;

  typedef struct packed {
    logic [22:0]        vref;
    logic [3:0]         gain;
    logic signed [20:0] trim;
    logic [2:0]         dig_uv;
    logic [2:0]         dig_mv;
    logic [2:0]         dig_v;
  } aos_cfg_t;

endpackage

### sv/aos_regs.sv
// ----------------------------------------------------------------------------
// aos_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module aos_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [aos_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output aos_pkg::aos_cfg_t              cfg
);
  import aos_pkg::*;

  logic [22:0] vref_r;
  logic [3:0]  gain_r;
  logic [20:0] trim_r;
  logic [2:0]  dig_uv_r;
  logic [2:0]  dig_mv_r;
  logic [2:0]  dig_v_r;
  logic [2:0]  index;
  logic        wr_en;

  assign index = paddr[CFG_ADDR_W-1:2];
  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vref_r   <= VREF_RESET;
      gain_r   <= GAIN_RESET;
      trim_r   <= TRIM_RESET;
      dig_uv_r <= DIG_UV_RESET;
      dig_mv_r <= DIG_MV_RESET;
      dig_v_r  <= DIG_V_RESET;
    end else if (wr_en) begin
      case (index)
        REG_VREF:   vref_r   <= pwdata[22:0];
        REG_GAIN:   gain_r   <= pwdata[3:0];
        REG_TRIM:   trim_r   <= pwdata[20:0];
        REG_DIG_UV: dig_uv_r <= pwdata[2:0];
        REG_DIG_MV: dig_mv_r <= pwdata[2:0];
        REG_DIG_V:  dig_v_r  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_VREF:   prdata = 32'(vref_r);
      REG_GAIN:   prdata = 32'(gain_r);
      REG_TRIM:   prdata = 32'(trim_r);
      REG_DIG_UV: prdata = 32'(dig_uv_r);
      REG_DIG_MV: prdata = 32'(dig_mv_r);
      REG_DIG_V:  prdata = 32'(dig_v_r);
      default:    prdata = 32'd0;
    endcase
  end

  assign cfg.vref   = vref_r;
  assign cfg.gain   = gain_r;
  assign cfg.trim   = trim_r;
  assign cfg.dig_uv = dig_uv_r;
  assign cfg.dig_mv = dig_mv_r;
  assign cfg.dig_v  = dig_v_r;

endmodule

### sv/aos_mul.sv
// ----------------------------------------------------------------------------
// aos_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module aos_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [aos_pkg::MUL_A_W-1:0]  op_a,
  input  logic signed [aos_pkg::MUL_B_W-1:0]  op_b,
  output logic signed [aos_pkg::PROD_W-1:0]   prod_r
);
  import aos_pkg::*;

  logic signed [PROD_W-1:0] prod_nxt;

  assign prod_nxt = PROD_W'(op_a) * PROD_W'(op_b);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

### sv/adc_average_offset_scale.sv
// ----------------------------------------------------------------------------
// adc_average_offset_scale
// Averages groups of converter frames and reports a calibrated zero offset
// or a scaled microvolt reading with display unit and digit count.
// ----------------------------------------------------------------------------
// Each accepted frame is added into the group accumulator.
// The frame that closes a group of 2^SAMPLES_LOG2 starts the sequencer: a
// calibration group goes straight to the output step, where its result is
// registered; a measurement group first passes the offset/trim add, then two
// passes through the one shared multiplier for gain and reference, then unit
// selection. The input is not ready until the sequencer is back in idle.
// A finished result waits in the output register; the next group's frames
// are taken while it waits, and the sequencer only stalls at its last step
// if the previous result has still not been taken.
module adc_average_offset_scale #(
  parameter int SAMPLES_LOG2 = 2,
  parameter int ADC_BITS     = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // frame[31:0]
  input  logic [0:0]                     in_tuser,   // mode[0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [63:0]                    out_tdata,  // microvolts[27:0], unit[29:28],
                                                     // decimals[32:30], offset_code[56:33]
  output logic [0:0]                     out_tuser,  // kind[0]
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [aos_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import aos_pkg::*;

  localparam int SAMPLE_W = ADC_BITS + 4;
  localparam int ACC_W    = SAMPLE_W + SAMPLES_LOG2;
  localparam int CNT_W    = SAMPLES_LOG2 + 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'((1 << SAMPLES_LOG2) - 1);
  localparam logic signed [PROD_W-1:0] UV_MILLI = PROD_W'(MILLI_LIMIT);
  localparam logic signed [PROD_W-1:0] UV_VOLT  = PROD_W'(VOLT_LIMIT);

  typedef enum logic [2:0] {S_IDLE, S_DIFF, S_MUL1, S_MUL2, S_OUT} state_t;

  aos_cfg_t cfg;

  state_t                   state_r, state_nxt;
  logic [ACC_W-1:0]         acc_r, acc_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     mode_r, mode_nxt;
  logic [ADC_BITS-1:0]      offset_r, offset_nxt;
  logic [ADC_BITS-1:0]      code_r, code_nxt;
  logic signed [DIFF_W-1:0] diff_r, diff_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_kind_r, out_kind_nxt;
  logic [UV_W-1:0]          out_uv_r, out_uv_nxt;
  logic [1:0]               out_unit_r, out_unit_nxt;
  logic [2:0]               out_dec_r, out_dec_nxt;

  logic [ACC_W-1:0]         acc_sum;
  logic                     accept;
  logic                     first_mode;
  logic                     mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  uv_full;
  logic signed [DIFF_W-1:0]  code_s, offset_s, trim_s;

  aos_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  aos_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  assign cfg_pready = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid & in_tready;
  assign acc_sum    = acc_r + ACC_W'(in_tdata[SAMPLE_W-1:0]);
  assign first_mode = (cnt_r == '0) ? in_tuser[0] : mode_r;

  assign code_s   = DIFF_W'(code_r);
  assign offset_s = DIFF_W'(offset_r);
  assign trim_s   = DIFF_W'(cfg.trim);

  // Floor division by 2^ADC_BITS is an arithmetic shift of the product.
  assign uv_full = prod_r >>> ADC_BITS;

  // First pass multiplies by the gain, the second pass by the reference.
  always_comb begin
    mul_en = (state_r == S_MUL1) || (state_r == S_MUL2);
    if (state_r == S_MUL1) begin
      mul_a = MUL_A_W'(diff_r);
      mul_b = MUL_B_W'(cfg.gain);
    end else begin
      mul_a = prod_r[MUL_A_W-1:0];
      mul_b = MUL_B_W'(cfg.vref);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    mode_nxt      = mode_r;
    offset_nxt    = offset_r;
    code_nxt      = code_r;
    diff_nxt      = diff_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_kind_nxt  = out_kind_r;
    out_uv_nxt    = out_uv_r;
    out_unit_nxt  = out_unit_r;
    out_dec_nxt   = out_dec_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt = first_mode;
          if (cnt_r == CNT_LAST) begin
            code_nxt  = acc_sum[ACC_W-1 -: ADC_BITS];
            acc_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = first_mode ? S_OUT : S_DIFF;
          end else begin
            acc_nxt = acc_sum;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      S_DIFF: begin
        diff_nxt  = code_s - offset_s + trim_s;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          if (mode_r) begin
            offset_nxt   = code_r;
            out_kind_nxt = KIND_CAL;
            out_uv_nxt   = '0;
            out_unit_nxt = UNIT_UV;
            out_dec_nxt  = 3'd0;
          end else begin
            out_kind_nxt = KIND_MEASURE;
            out_uv_nxt   = uv_full[UV_W-1:0];
            if (uv_full < UV_MILLI) begin
              out_unit_nxt = UNIT_UV;
              out_dec_nxt  = cfg.dig_uv;
            end else if (uv_full < UV_VOLT) begin
              out_unit_nxt = UNIT_MV;
              out_dec_nxt  = cfg.dig_mv;
            end else begin
              out_unit_nxt = UNIT_V;
              out_dec_nxt  = cfg.dig_v;
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      cnt_r       <= '0;
      mode_r      <= 1'b0;
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      mode_r      <= mode_nxt;
      offset_r    <= offset_nxt;
      out_valid_r <= out_valid_nxt;
    end
    code_r     <= code_nxt;
    diff_r     <= diff_nxt;
    out_kind_r <= out_kind_nxt;
    out_uv_r   <= out_uv_nxt;
    out_unit_r <= out_unit_nxt;
    out_dec_r  <= out_dec_nxt;
  end

  // The offset only changes when a result is loaded, so it matches the
  // result that is currently held.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {7'd0, OFFS_W'(offset_r), out_dec_r, out_unit_r, out_uv_r};

endmodule
